@@ rtl/assert_macros.svh @@
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`endif

@@ rtl/sfp_pkg.sv @@
package sfp_pkg;

   localparam int KIND_W  = 3;
   localparam int FLOOR_W = 4;
   localparam int STEPS_W = 20;
   localparam int PHASE_W = 3;
   localparam int COIL_W  = 4;
   localparam int SPF_W   = 16;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 16;

   localparam logic [SPF_W-1:0]   SPF_RESET       = 16'd4096;
   localparam logic [FLOOR_W-1:0] TOP_FLOOR_RESET = 4'd4;
   localparam logic [FLOOR_W-1:0] FLOOR_HOME      = 4'd1;
   localparam logic [COIL_W-1:0]  COILS_OFF       = 4'h0;

   typedef enum logic [KIND_W-1:0] {
      KIND_TICK       = 3'd0,
      KIND_MOVE_FLOOR = 3'd1,
      KIND_STOP       = 3'd2,
      KIND_HOME       = 3'd3,
      KIND_RAW_STEPS  = 3'd4
   } kind_type;

   typedef enum logic {
      CSR_STEPS_PER_FLOOR = 1'b0,
      CSR_TOP_FLOOR       = 1'b1
   } csr_index_type;

   typedef struct packed {
      kind_type            kind;
      logic [FLOOR_W-1:0]  floor;
      logic [STEPS_W-1:0]  steps;
      logic                direction;
      logic                photo_sensor;
   } cmd_type;

   typedef struct packed {
      logic [COIL_W-1:0]   coils;
      logic                busy_res;
      logic [FLOOR_W-1:0]  floor_now;
      logic [FLOOR_W-1:0]  floor_goal;
      logic                homed;
   } rsp_type;

   // half-step drive pattern, bit0 is IN1
   function automatic logic [COIL_W-1:0] coil_of(input logic [PHASE_W-1:0] ph);
      logic [COIL_W-1:0] pat;
      case (ph)
         3'd0:    pat = 4'h1;
         3'd1:    pat = 4'h3;
         3'd2:    pat = 4'h2;
         3'd3:    pat = 4'h6;
         3'd4:    pat = 4'h4;
         3'd5:    pat = 4'hC;
         3'd6:    pat = 4'h8;
         default: pat = 4'h9;
      endcase
      return pat;
   endfunction

endpackage

@@ rtl/sfp_cmd_stage.sv @@
module sfp_cmd_stage
   import sfp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // floor[3:0], steps[23:4], direction[24], photo_sensor[25], zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // kind[2:0]
   input  logic [KIND_W-1:0]     req_tuser,
   input  logic                  out_free,
   output logic                  cmd_fire,
   output cmd_type               cmd
);

   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   logic    take;

   assign cmd_fire   = valid_ff && out_free;
   assign req_tready = !valid_ff || out_free;
   assign take       = req_tvalid && req_tready;
   assign cmd        = cmd_ff;

   always_comb begin
      cmd_in.kind         = kind_type'(req_tuser);
      cmd_in.floor        = req_tdata[3:0];
      cmd_in.steps        = req_tdata[23:4];
      cmd_in.direction    = req_tdata[24];
      cmd_in.photo_sensor = req_tdata[25];
      valid_in            = take || (valid_ff && !cmd_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

@@ rtl/sfp_core.sv @@
module sfp_core
   import sfp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_fire,
   input  cmd_type          cmd,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [SPF_W-1:0] csr_wdata,
   output rsp_type          rsp_next
);

   logic [SPF_W-1:0]   spf_ff;
   logic [FLOOR_W-1:0] top_ff;

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [STEPS_W-1:0] steps_left_ff, steps_left_in;
   logic               move_down_ff, move_down_in;
   logic               busy_ff, busy_in;
   logic               running_ff, running_in;
   logic               homing_ff, homing_in;
   logic               homed_ff, homed_in;
   logic [FLOOR_W-1:0] at_floor_ff, at_floor_in;
   logic [FLOOR_W-1:0] goal_floor_ff, goal_floor_in;
   logic [COIL_W-1:0]  coil_ff, coil_in;

   logic [PHASE_W-1:0] phase_up, phase_dn, phase_run;
   logic [FLOOR_W-1:0] diff;
   logic [STEPS_W-1:0] run_len;
   logic               floor_ok;

   assign phase_up = phase_ff + PHASE_W'(1);
   assign phase_dn = phase_ff - PHASE_W'(1);
   assign phase_run = move_down_ff ? phase_dn : phase_up;

   always_comb begin
      diff = (cmd.floor > at_floor_ff) ? (cmd.floor - at_floor_ff)
                                       : (at_floor_ff - cmd.floor);
      run_len = STEPS_W'(diff) * STEPS_W'(spf_ff);
      floor_ok = (cmd.floor != '0) && (cmd.floor <= top_ff) && !busy_ff &&
                 (cmd.floor != at_floor_ff) && homed_ff;
   end

   always_comb begin
      phase_in      = phase_ff;
      steps_left_in = steps_left_ff;
      move_down_in  = move_down_ff;
      busy_in       = busy_ff;
      running_in    = running_ff;
      homing_in     = homing_ff;
      homed_in      = homed_ff;
      at_floor_in   = at_floor_ff;
      goal_floor_in = goal_floor_ff;
      coil_in       = coil_ff;
      case (cmd.kind)
         KIND_TICK: begin
            if (homing_ff) begin
               if (cmd.photo_sensor) begin
                  coil_in       = COILS_OFF;
                  steps_left_in = '0;
                  busy_in       = 1'b0;
                  homing_in     = 1'b0;
                  homed_in      = 1'b1;
                  at_floor_in   = FLOOR_HOME;
                  goal_floor_in = FLOOR_HOME;
               end else begin
                  phase_in = phase_dn;
                  coil_in  = coil_of(phase_dn);
               end
            end else if (running_ff) begin
               if (steps_left_ff != '0) begin
                  phase_in      = phase_run;
                  coil_in       = coil_of(phase_run);
                  steps_left_in = steps_left_ff - STEPS_W'(1);
               end else begin
                  // extra tick after the last step settles on the goal
                  running_in  = 1'b0;
                  coil_in     = COILS_OFF;
                  at_floor_in = goal_floor_ff;
                  busy_in     = 1'b0;
               end
            end
         end
         KIND_MOVE_FLOOR: begin
            if (floor_ok) begin
               goal_floor_in = cmd.floor;
               if (run_len != '0) begin
                  steps_left_in = run_len;
                  move_down_in  = (cmd.floor < at_floor_ff);
                  busy_in       = 1'b1;
                  running_in    = 1'b1;
               end
            end
         end
         KIND_STOP: begin
            steps_left_in = '0;
            busy_in       = 1'b0;
            running_in    = 1'b0;
            homing_in     = 1'b0;
            coil_in       = COILS_OFF;
         end
         KIND_HOME: begin
            if (!busy_ff) begin
               phase_in      = '0;
               steps_left_in = '0;
               running_in    = 1'b0;
               homing_in     = 1'b1;
               busy_in       = 1'b1;
            end
         end
         KIND_RAW_STEPS: begin
            if (homed_ff && !busy_ff && (cmd.steps != '0)) begin
               steps_left_in = cmd.steps;
               move_down_in  = cmd.direction;
               busy_in       = 1'b1;
               running_in    = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_next.coils      = coil_in;
      rsp_next.busy_res   = busy_in;
      rsp_next.floor_now  = at_floor_in;
      rsp_next.floor_goal = goal_floor_in;
      rsp_next.homed      = homed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spf_ff <= SPF_RESET;
         top_ff <= TOP_FLOOR_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_STEPS_PER_FLOOR: spf_ff <= csr_wdata;
            CSR_TOP_FLOOR:       top_ff <= csr_wdata[FLOOR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= '0;
         steps_left_ff <= '0;
         move_down_ff  <= 1'b0;
         busy_ff       <= 1'b0;
         running_ff    <= 1'b0;
         homing_ff     <= 1'b0;
         homed_ff      <= 1'b0;
         at_floor_ff   <= FLOOR_HOME;
         goal_floor_ff <= FLOOR_HOME;
         coil_ff       <= COILS_OFF;
      end else if (cmd_fire) begin
         phase_ff      <= phase_in;
         steps_left_ff <= steps_left_in;
         move_down_ff  <= move_down_in;
         busy_ff       <= busy_in;
         running_ff    <= running_in;
         homing_ff     <= homing_in;
         homed_ff      <= homed_in;
         at_floor_ff   <= at_floor_in;
         goal_floor_ff <= goal_floor_in;
         coil_ff       <= coil_in;
      end
   end

endmodule

@@ rtl/sfp_rsp_stage.sv @@
module sfp_rsp_stage
   import sfp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  rsp_type               rsp_next,
   output logic                  out_free,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // coils[3:0], busy_res[4], floor_now[8:5], floor_goal[12:9], homed[13], zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic    valid_ff, valid_in;
   rsp_type rsp_ff;

   assign out_free   = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign valid_in   = load || (valid_ff && !rsp_tready);

   assign rsp_tdata = {2'b00, rsp_ff.homed, rsp_ff.floor_goal, rsp_ff.floor_now,
                       rsp_ff.busy_res, rsp_ff.coils};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_next;
      end
   end

endmodule

@@ rtl/stepper_floor_positioner.sv @@
// path: input register, state update, then result register, which drives rsp
// throughput: one word per cycle unless rsp stalls; input register feeds one state update
// while a finished result waits on rsp the input register takes one more word, then stalls
// reset is synchronous, active high: motion state, floors and config registers
// return to their defaults at once, with no clearing pass
module stepper_floor_positioner
   import sfp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // floor[3:0], steps[23:4], direction[24], photo_sensor[25], zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // kind[2:0]
   input  logic [KIND_W-1:0]     req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // coils[3:0], busy_res[4], floor_now[8:5], floor_goal[12:9], homed[13], zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [SPF_W-1:0]      csr_wdata
);

   logic    out_free;
   logic    cmd_fire;
   cmd_type cmd;
   rsp_type rsp_next;

   sfp_cmd_stage u_cmd (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .out_free   (out_free),
      .cmd_fire   (cmd_fire),
      .cmd        (cmd)
   );

   sfp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cmd_fire  (cmd_fire),
      .cmd       (cmd),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_next  (rsp_next)
   );

   sfp_rsp_stage u_rsp (
      .clock      (clock),
      .reset      (reset),
      .load       (cmd_fire),
      .rsp_next   (rsp_next),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ rtl/sfp_checker.sv @@
`include "assert_macros.svh"

module sfp_checker
   import sfp_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic               rsp_stall;
   logic [COIL_W-1:0]  rsp_coils;
   logic               rsp_busy;
   logic [FLOOR_W-1:0] rsp_floor_now;
   logic [FLOOR_W-1:0] rsp_floor_goal;
   logic               rsp_homed;
   logic               rsp_off_home;

   assign rsp_stall      = rsp_tvalid && !rsp_tready;
   assign rsp_coils      = rsp_tdata[3:0];
   assign rsp_busy       = rsp_tdata[4];
   assign rsp_floor_now  = rsp_tdata[8:5];
   assign rsp_floor_goal = rsp_tdata[12:9];
   assign rsp_homed      = rsp_tdata[13];
   assign rsp_off_home   = (rsp_floor_now != FLOOR_HOME) || (rsp_floor_goal != FLOOR_HOME);

   // a stalled result word holds
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_stall |=> rsp_tvalid && $stable(rsp_tdata))

   // input side only backs up behind a stalled result
   `ASSERT_CLK(a_req_backpressure, clock, reset, !req_tready |-> rsp_stall)

   // coils are driven only while moving or homing
   `ASSERT_NEVER(a_coils_idle, clock, reset, rsp_tvalid && (rsp_coils != COILS_OFF) && !rsp_busy)

   // no floor change is possible before homing
   `ASSERT_NEVER(a_floor_unhomed, clock, reset, rsp_tvalid && !rsp_homed && rsp_off_home)

endmodule

bind stepper_floor_positioner sfp_checker u_sfp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ tb/sv/tb_stepper_floor_positioner.sv @@
`timescale 1ns / 100ps

module tb_stepper_floor_positioner;
   import sfp_pkg::*;

   localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd5;
   localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE_C = 3'd7;

   // drive patterns for phases 7 down to 0, one nibble each
   localparam logic [31:0] HALF_STEP_TABLE = 32'h98C46231;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 4;
   localparam int WORD_TARGET    = 760;
   localparam int TICK_CAP       = 120;

   typedef struct packed {
      logic [COIL_W-1:0]  coils;
      logic               busy;
      logic [FLOOR_W-1:0] floor_now;
      logic [FLOOR_W-1:0] floor_goal;
      logic               homed;
   } car_status_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [KIND_W-1:0]     req_tuser  = KIND_TICK;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic                  csr_index  = CSR_STEPS_PER_FLOOR;
   logic [SPF_W-1:0]      csr_wdata  = '0;

   stepper_floor_positioner dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // car state as the block should hold it
   logic [PHASE_W-1:0] car_phase  = '0;
   logic [STEPS_W-1:0] car_left   = '0;
   logic               car_down   = 1'b0;
   logic               car_busy   = 1'b0;
   logic               car_run    = 1'b0;
   logic               car_homing = 1'b0;
   logic               car_homed  = 1'b0;
   logic [FLOOR_W-1:0] car_floor  = FLOOR_HOME;
   logic [FLOOR_W-1:0] car_goal   = FLOOR_HOME;
   logic [COIL_W-1:0]  car_coils  = COILS_OFF;
   logic [SPF_W-1:0]   cfg_spf    = SPF_RESET;
   logic [FLOOR_W-1:0] cfg_top    = TOP_FLOOR_RESET;

   car_status_type car_status_q[$];
   car_status_type seen_status;
   car_status_type want_status;

   int words_sent  = 0;
   int mismatches  = 0;
   int idle_cycles = 0;
   int stall_left  = 0;
   bit gap_en      = 1'b1;
   bit stall_en    = 1'b1;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [FLOOR_W-1:0] rand_floor();
      return FLOOR_W'($urandom);
   endfunction

   function automatic logic [STEPS_W-1:0] rand_steps();
      return STEPS_W'($urandom);
   endfunction

   function automatic logic rand_bit();
      return 1'($urandom);
   endfunction

   function automatic logic [KIND_W-1:0] rand_kind();
      return KIND_W'($urandom_range(0, 7));
   endfunction

   task automatic begin_run(input logic [STEPS_W-1:0] count, input logic down);
      if (car_homed && !car_busy && count != '0) begin
         car_left = count;
         car_down = down;
         car_busy = 1'b1;
         car_run  = 1'b1;
      end
   endtask

   task automatic advance_car(input logic [KIND_W-1:0] kind, input logic [FLOOR_W-1:0] fl,
                              input logic [STEPS_W-1:0] st, input logic dn, input logic ps);
      logic [FLOOR_W-1:0] diff;
      logic [35:0]        run_len;
      car_status_type     s;
      case (kind)
         KIND_TICK: begin
            if (car_homing) begin
               if (ps) begin
                  car_coils  = COILS_OFF;
                  car_left   = '0;
                  car_busy   = 1'b0;
                  car_homing = 1'b0;
                  car_homed  = 1'b1;
                  car_floor  = FLOOR_HOME;
                  car_goal   = FLOOR_HOME;
               end else begin
                  car_phase = car_phase - PHASE_W'(1);
                  car_coils = HALF_STEP_TABLE[{car_phase, 2'b00} +: 4];
               end
            end else if (car_run) begin
               if (car_left != '0) begin
                  car_phase = car_down ? car_phase - PHASE_W'(1) : car_phase + PHASE_W'(1);
                  car_coils = HALF_STEP_TABLE[{car_phase, 2'b00} +: 4];
                  car_left  = car_left - STEPS_W'(1);
               end else begin
                  // the extra tick after the last step parks the car
                  car_run   = 1'b0;
                  car_coils = COILS_OFF;
                  car_floor = car_goal;
                  car_busy  = 1'b0;
               end
            end
         end
         KIND_MOVE_FLOOR: begin
            if (fl != '0 && fl <= cfg_top && !car_busy && fl != car_floor && car_homed) begin
               car_goal = fl;
               diff     = (fl > car_floor) ? fl - car_floor : car_floor - fl;
               run_len  = 36'(diff) * 36'(cfg_spf);
               begin_run(run_len[STEPS_W-1:0], fl < car_floor);
            end
         end
         KIND_STOP: begin
            car_left   = '0;
            car_busy   = 1'b0;
            car_run    = 1'b0;
            car_homing = 1'b0;
            car_coils  = COILS_OFF;
         end
         KIND_HOME: begin
            if (!car_busy) begin
               car_phase  = '0;
               car_left   = '0;
               car_run    = 1'b0;
               car_homing = 1'b1;
               car_busy   = 1'b1;
            end
         end
         KIND_RAW_STEPS: begin_run(st, dn);
         default: ;
      endcase
      s.coils      = car_coils;
      s.busy       = car_busy;
      s.floor_now  = car_floor;
      s.floor_goal = car_goal;
      s.homed      = car_homed;
      car_status_q.push_back(s);
   endtask

   task automatic send_word(input logic [KIND_W-1:0] kind, input logic [FLOOR_W-1:0] fl,
                            input logic [STEPS_W-1:0] st, input logic dn, input logic ps);
      int gap;
      gap = gap_en ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {6'b0, ps, dn, st, fl};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      advance_car(kind, fl, st, dn, ps);
      words_sent++;
   endtask

   // hold off until every result is back and the pipeline is quiet
   task automatic settle_car();
      req_tvalid <= 1'b0;
      while (car_status_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [SPF_W-1:0] spf, input logic [FLOOR_W-1:0] top);
      csr_we    <= 1'b1;
      csr_index <= CSR_STEPS_PER_FLOOR;
      csr_wdata <= spf;
      @(posedge clock);
      csr_index <= CSR_TOP_FLOOR;
      csr_wdata <= {{(SPF_W-FLOOR_W){1'b0}}, top};
      @(posedge clock);
      csr_we  <= 1'b0;
      cfg_spf = spf;
      cfg_top = top;
   endtask

   task automatic note_mismatch(input string what, input logic [15:0] got,
                                input logic [15:0] want);
      mismatches++;
      $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
   endtask

   task automatic test_startup_state();
      send_word(KIND_TICK, 4'hF, 20'hFFFFF, 1'b1, 1'b1);
      send_word(KIND_SPARE_A, 4'h0, 20'h0, 1'b0, 1'b0);
      send_word(KIND_SPARE_B, 4'hF, 20'hFFFFF, 1'b1, 1'b1);
      send_word(KIND_SPARE_C, 4'h3, 20'h5, 1'b0, 1'b1);
      // no motion before homing
      send_word(KIND_MOVE_FLOOR, 4'h2, 20'h0, 1'b0, 1'b0);
      send_word(KIND_RAW_STEPS, 4'h0, 20'hFFFFF, 1'b1, 1'b0);
      send_word(KIND_STOP, 4'h0, 20'h0, 1'b0, 1'b0);
   endtask

   task automatic test_homing();
      settle_car();
      set_config(16'd1, 4'd4);
      send_word(KIND_HOME, 4'h0, 20'h0, 1'b0, 1'b1);
      send_word(KIND_TICK, 4'h0, 20'h0, 1'b0, 1'b0);
      send_word(KIND_TICK, 4'h0, 20'h0, 1'b0, 1'b0);
      send_word(KIND_TICK, 4'h0, 20'h0, 1'b0, 1'b1);
      // second home while busy is dropped, stop keeps homed
      send_word(KIND_HOME, 4'h0, 20'h0, 1'b0, 1'b0);
      send_word(KIND_HOME, 4'h0, 20'h0, 1'b0, 1'b0);
      send_word(KIND_STOP, 4'h0, 20'h0, 1'b0, 1'b0);
      // sensor already set: first tick completes at once
      send_word(KIND_HOME, 4'h0, 20'h0, 1'b0, 1'b0);
      send_word(KIND_TICK, 4'h0, 20'h0, 1'b0, 1'b1);
   endtask

   task automatic test_floor_moves();
      int n;
      send_word(KIND_MOVE_FLOOR, 4'd0, 20'h0, 1'b0, 1'b0);
      send_word(KIND_MOVE_FLOOR, 4'd15, 20'h0, 1'b0, 1'b0);
      send_word(KIND_MOVE_FLOOR, 4'd1, 20'h0, 1'b0, 1'b0);
      send_word(KIND_MOVE_FLOOR, 4'd4, 20'h0, 1'b0, 1'b0);
      send_word(KIND_MOVE_FLOOR, 4'd2, 20'h0, 1'b0, 1'b0);
      n = 0;
      while (car_busy && n < TICK_CAP) begin
         send_word(KIND_TICK, 4'h0, 20'h0, 1'b0, 1'b0);
         n++;
      end
      send_word(KIND_RAW_STEPS, 4'h0, 20'h0, 1'b0, 1'b0);
      send_word(KIND_RAW_STEPS, 4'hF, 20'hFFFFF, 1'b1, 1'b1);
      send_word(KIND_TICK, 4'h0, 20'h0, 1'b0, 1'b0);
      send_word(KIND_STOP, 4'hF, 20'hFFFFF, 1'b1, 1'b1);
   endtask

   task automatic test_config_extremes();
      gap_en   = 1'b0;
      stall_en = 1'b0;
      settle_car();
      // zero steps per floor: goal moves, car does not
      set_config(16'd0, 4'd15);
      send_word(KIND_MOVE_FLOOR, 4'd2, 20'h0, 1'b0, 1'b0);
      send_word(KIND_TICK, 4'h0, 20'h0, 1'b0, 1'b0);
      settle_car();
      set_config(16'hFFFF, 4'd15);
      send_word(KIND_MOVE_FLOOR, 4'd15, 20'h0, 1'b0, 1'b0);
      send_word(KIND_TICK, 4'h0, 20'h0, 1'b0, 1'b0);
      send_word(KIND_TICK, 4'h0, 20'h0, 1'b0, 1'b0);
      send_word(KIND_STOP, 4'h0, 20'h0, 1'b0, 1'b0);
      gap_en   = 1'b1;
      stall_en = 1'b1;
   endtask

   task automatic test_random_traffic();
      int start;
      int n;
      int pick;
      start = words_sent;
      while (words_sent - start < WORD_TARGET) begin
         settle_car();
         case ($urandom_range(0, 7))
            0:       set_config(16'hFFFF, FLOOR_W'($urandom_range(1, 15)));
            1:       set_config(16'd1, 4'd15);
            2:       set_config(SPF_W'($urandom_range(1, 8)), 4'd1);
            3:       set_config(SPF_W'($urandom_range(0, 8)), FLOOR_W'($urandom_range(0, 15)));
            default: set_config(SPF_W'($urandom_range(1, 8)), FLOOR_W'($urandom_range(1, 15)));
         endcase
         gap_en   = $urandom_range(0, 3) != 0;
         stall_en = $urandom_range(0, 3) != 0;
         repeat (6) begin
            if (words_sent - start >= WORD_TARGET) break;
            pick = $urandom_range(0, 9);
            case (pick)
               0, 1: begin
                  send_word(KIND_HOME, rand_floor(), rand_steps(), rand_bit(), rand_bit());
                  n = 0;
                  while (car_homing && n < 40) begin
                     send_word(KIND_TICK, rand_floor(), rand_steps(), rand_bit(),
                               $urandom_range(0, 4) == 0);
                     n++;
                  end
                  if (car_busy)
                     send_word(KIND_STOP, rand_floor(), rand_steps(), rand_bit(), rand_bit());
               end
               2, 3, 4, 5, 6: begin
                  if (pick <= 4)
                     send_word(KIND_MOVE_FLOOR,
                               ($urandom_range(0, 5) == 0) ? rand_floor()
                                                           : FLOOR_W'($urandom_range(1, cfg_top)),
                               rand_steps(), rand_bit(), rand_bit());
                  else
                     send_word(KIND_RAW_STEPS, rand_floor(),
                               ($urandom_range(0, 5) == 0) ? rand_steps()
                                                           : STEPS_W'($urandom_range(0, 40)),
                               rand_bit(), rand_bit());
                  n = 0;
                  while (car_busy && n < TICK_CAP) begin
                     if ($urandom_range(0, 99) == 0)
                        send_word(KIND_STOP, rand_floor(), rand_steps(), rand_bit(), rand_bit());
                     else
                        send_word(KIND_TICK, rand_floor(), rand_steps(), rand_bit(), rand_bit());
                     n++;
                  end
                  if (car_busy)
                     send_word(KIND_STOP, rand_floor(), rand_steps(), rand_bit(), rand_bit());
               end
               7: send_word(KIND_STOP, rand_floor(), rand_steps(), rand_bit(), rand_bit());
               default: begin
                  repeat ($urandom_range(1, 4))
                     send_word(rand_kind(), rand_floor(), rand_steps(), rand_bit(), rand_bit());
               end
            endcase
         end
      end
   endtask

   // result side backpressure
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (stall_en && $urandom_range(0, 4) == 0) begin
         stall_left <= pick_gap();
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // each result word against the oldest expected status
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_status.coils      = rsp_tdata[3:0];
         seen_status.busy       = rsp_tdata[4];
         seen_status.floor_now  = rsp_tdata[8:5];
         seen_status.floor_goal = rsp_tdata[12:9];
         seen_status.homed      = rsp_tdata[13];
         if (car_status_q.size() == 0) begin
            note_mismatch("result word with nothing expected", rsp_tdata, 16'h0);
         end else begin
            want_status = car_status_q.pop_front();
            if (seen_status.coils !== want_status.coils)
               note_mismatch("coils", 16'(seen_status.coils), 16'(want_status.coils));
            if (seen_status.busy !== want_status.busy)
               note_mismatch("busy", 16'(seen_status.busy), 16'(want_status.busy));
            if (seen_status.floor_now !== want_status.floor_now)
               note_mismatch("floor_now", 16'(seen_status.floor_now),
                             16'(want_status.floor_now));
            if (seen_status.floor_goal !== want_status.floor_goal)
               note_mismatch("floor_goal", 16'(seen_status.floor_goal),
                             16'(want_status.floor_goal));
            if (seen_status.homed !== want_status.homed)
               note_mismatch("homed", 16'(seen_status.homed), 16'(want_status.homed));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_startup_state();
      test_homing();
      test_floor_moves();
      test_config_extremes();
      test_random_traffic();
      settle_car();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && car_status_q.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/sfp_pkg.sv
rtl/sfp_cmd_stage.sv
rtl/sfp_core.sv
rtl/sfp_rsp_stage.sv
rtl/stepper_floor_positioner.sv
rtl/sfp_checker.sv
tb/sv/tb_stepper_floor_positioner.sv
